/* design/next_permutation_with_repeats_defines.svh */
// Assertion macros for the arrangement sequencer.
`ifndef NEXT_PERMUTATION_WITH_REPEATS_DEFINES_SVH
`define NEXT_PERMUTATION_WITH_REPEATS_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define NPR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define NPR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* design/npr_pkg.sv */
package npr_pkg;

	localparam int CFG_W    = 5;
	localparam int IN_IDX_W = 4;
	localparam int IN_VAL_W = 4;
	localparam int ARR_W    = 64;
	localparam int CNT_W    = 45;

	localparam logic [CFG_W-1:0] CFG_LEN_RESET = 5'd16;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_FIND,
		OP_SWAP_P,
		OP_SWAP_Q,
		OP_REV_RD,
		OP_REV_WR_LO,
		OP_REV_WR_HI,
		OP_SUCCESS,
		OP_FAIL,
		OP_CAPTURE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic len_one;
		logic scan_hit;
		logic scan_end;
		logic find_hit;
		logic rev_more;
	} dp_stat_t;

endpackage

/* design/npr_datapath.sv */
module npr_datapath import npr_pkg::*; #(
	parameter int MAX_LEN    = 16,
	parameter int LABEL_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [IN_IDX_W-1:0]  index,
	input  logic [IN_VAL_W-1:0]  value,
	input  dp_cmd_t              dp_cmd,
	output dp_stat_t             stat,
	output logic [ARR_W-1:0]     arrangement,
	output logic                 exhausted,
	output logic [CNT_W-1:0]     produced_count
);

	localparam int PW    = $clog2(MAX_LEN);
	localparam int ROW_W = MAX_LEN * LABEL_BITS;

	typedef logic [LABEL_BITS-1:0] label_t;
	typedef logic [PW-1:0]         pos_t;

	localparam logic [CFG_W-1:0] MaxLenCfg = CFG_W'(MAX_LEN);
	localparam pos_t             LastPos   = PW'(MAX_LEN - 1);

	label_t            row_q [MAX_LEN];
	logic [CFG_W-1:0]  len_cfg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	pos_t   ptr_q, p_q, lo_q;
	label_t prev_q, pv_q, tmp_q;

	logic [ARR_W-1:0]  arrangement_q;
	logic              exhausted_q;
	logic [CNT_W-1:0]  produced_count_q;

	pos_t   last_pos;
	pos_t   rd_pos;
	label_t rd_label;
	logic   wr_en;
	pos_t   wr_pos;
	label_t wr_label;

	logic [ROW_W-1:0]       row_flat;
	logic [ROW_W+ARR_W-1:0] row_ext;

	// Clamp the configured length into 1..MAX_LEN and keep its last position.
	always_comb begin
		if (len_cfg_q == '0) begin
			last_pos = '0;
		end else if (len_cfg_q > MaxLenCfg) begin
			last_pos = LastPos;
		end else begin
			last_pos = PW'(len_cfg_q - CFG_W'(1));
		end
	end

	// Single label read port.
	always_comb begin
		unique case (dp_cmd.op)
			OP_SCAN_INIT: rd_pos = last_pos;
			OP_REV_RD:    rd_pos = lo_q;
			default:      rd_pos = ptr_q;
		endcase
	end
	assign rd_label = row_q[rd_pos];

	// Single label write port.
	always_comb begin
		wr_en    = 1'b0;
		wr_pos   = ptr_q;
		wr_label = tmp_q;
		unique case (dp_cmd.op)
			OP_LOAD: begin
				wr_en    = ({1'b0, index} < MaxLenCfg);
				wr_pos   = index[PW-1:0];
				wr_label = LABEL_BITS'(value);
			end
			OP_SWAP_P: begin
				wr_en    = 1'b1;
				wr_pos   = p_q;
				wr_label = tmp_q;
			end
			OP_SWAP_Q: begin
				wr_en    = 1'b1;
				wr_pos   = ptr_q;
				wr_label = pv_q;
			end
			OP_REV_WR_LO: begin
				wr_en    = 1'b1;
				wr_pos   = lo_q;
				wr_label = rd_label;
			end
			OP_REV_WR_HI: begin
				wr_en    = 1'b1;
				wr_pos   = ptr_q;
				wr_label = tmp_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign stat.len_one  = (last_pos == '0);
	assign stat.scan_hit = (rd_label < prev_q);
	assign stat.scan_end = (ptr_q == '0);
	assign stat.find_hit = (rd_label > pv_q);
	assign stat.rev_more = (lo_q < ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				row_q[i] <= '0;
			end
		end else if (wr_en) begin
			row_q[wr_pos] <= wr_label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= CFG_LEN_RESET;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_cfg_q <= cfg_data;
			end
			unique case (dp_cmd.op)
				OP_LOAD: begin
					cnt_q  <= '0;
					done_q <= 1'b0;
				end
				OP_SUCCESS: begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					done_q <= 1'b0;
				end
				OP_FAIL: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the scan, search and reversal.
	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			OP_SCAN_INIT: begin
				prev_q <= rd_label;
				ptr_q  <= last_pos - PW'(1);
			end
			OP_SCAN: begin
				if (stat.scan_hit) begin
					p_q   <= ptr_q;
					pv_q  <= rd_label;
					ptr_q <= last_pos;
				end else begin
					prev_q <= rd_label;
					ptr_q  <= ptr_q - PW'(1);
				end
			end
			OP_FIND: begin
				if (stat.find_hit) begin
					tmp_q <= rd_label;
				end else begin
					ptr_q <= ptr_q - PW'(1);
				end
			end
			OP_SWAP_Q: begin
				lo_q  <= p_q + PW'(1);
				ptr_q <= last_pos;
			end
			OP_REV_RD: begin
				tmp_q <= rd_label;
			end
			OP_REV_WR_HI: begin
				lo_q  <= lo_q + PW'(1);
				ptr_q <= ptr_q - PW'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			row_flat[i*LABEL_BITS +: LABEL_BITS] = row_q[i];
		end
	end
	assign row_ext = {{ARR_W{1'b0}}, row_flat};

	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_CAPTURE) begin
			arrangement_q    <= row_ext[ARR_W-1:0];
			exhausted_q      <= done_q;
			produced_count_q <= cnt_q;
		end
	end

	assign arrangement    = arrangement_q;
	assign exhausted      = exhausted_q;
	assign produced_count = produced_count_q;

endmodule

/* design/npr_ctrl.sv */
module npr_ctrl import npr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     cmd,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output logic     in_stall,
	output logic     out_valid,
	output dp_cmd_t  dp_cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_INIT,
		S_SCAN,
		S_FIND,
		S_SWAP_P,
		S_SWAP_Q,
		S_REV_RD,
		S_REV_WR_LO,
		S_REV_WR_HI,
		S_FAIL,
		S_REPLY
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d    = state_q;
		dp_cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_LOAD) begin
						dp_cmd.op = OP_LOAD;
						state_d   = S_REPLY;
					end else begin
						state_d   = S_SCAN_INIT;
					end
				end
			end
			S_SCAN_INIT: begin
				if (stat.len_one) begin
					state_d = S_FAIL;
				end else begin
					dp_cmd.op = OP_SCAN_INIT;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				dp_cmd.op = OP_SCAN;
				if (stat.scan_hit) begin
					state_d = S_FIND;
				end else if (stat.scan_end) begin
					state_d = S_FAIL;
				end
			end
			S_FIND: begin
				dp_cmd.op = OP_FIND;
				if (stat.find_hit) begin
					state_d = S_SWAP_P;
				end
			end
			S_SWAP_P: begin
				dp_cmd.op = OP_SWAP_P;
				state_d   = S_SWAP_Q;
			end
			S_SWAP_Q: begin
				dp_cmd.op = OP_SWAP_Q;
				state_d   = S_REV_RD;
			end
			S_REV_RD: begin
				if (stat.rev_more) begin
					dp_cmd.op = OP_REV_RD;
					state_d   = S_REV_WR_LO;
				end else begin
					dp_cmd.op = OP_SUCCESS;
					state_d   = S_REPLY;
				end
			end
			S_REV_WR_LO: begin
				dp_cmd.op = OP_REV_WR_LO;
				state_d   = S_REV_WR_HI;
			end
			S_REV_WR_HI: begin
				dp_cmd.op = OP_REV_WR_HI;
				state_d   = S_REV_RD;
			end
			S_FAIL: begin
				dp_cmd.op = OP_FAIL;
				state_d   = S_REPLY;
			end
			S_REPLY: begin
				if (out_free) begin
					dp_cmd.op = OP_CAPTURE;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.op == OP_CAPTURE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/next_permutation_with_repeats.sv */
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_valid / cfg_ready   cfg_data (active length)
// in        in         in_valid / in_stall     cmd, index, value
// out       out        out_valid / out_stall   arrangement, exhausted, produced_count
//
// A load transaction passes to the reply state and is captured once the output is free.
// An advance with active length L, ascent at p and swap partner at q scans down for the
// ascent, searches for q, swaps p and q and reverses the tail before capture, or goes to
// the reply when no ascent exists: one label read port, so one label a cycle.
// The input reopens the cycle after capture. Reset clears row, count and flag and sets length to 16.
// A stalled result waits in the output register; only the next capture waits on it.
`include "next_permutation_with_repeats_defines.svh"

module next_permutation_with_repeats import npr_pkg::*; #(
	parameter int MAX_LEN    = 16,
	parameter int LABEL_BITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	// input transactions
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [IN_IDX_W-1:0] index,
	input  logic [IN_VAL_W-1:0] value,
	// result transactions
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ARR_W-1:0]    arrangement,
	output logic                exhausted,
	output logic [CNT_W-1:0]    produced_count
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     cfg_we;

	// Length writes must arrive only while the block is idle; the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// One transaction at a time: load, or scan, search, swap, reverse or fail; then reply.
	npr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.dp_cmd    (dp_cmd)
	);

	// Hold the row, the count, the flag and the result register.
	npr_datapath #(
		.MAX_LEN    (MAX_LEN),
		.LABEL_BITS (LABEL_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.index          (index),
		.value          (value),
		.dp_cmd         (dp_cmd),
		.stat           (dp_stat),
		.arrangement    (arrangement),
		.exhausted      (exhausted),
		.produced_count (produced_count)
	);

	// Never overwrite a result that is still waiting to be taken.
	`NPR_ASSERT_NEVER(a_capture_free, (dp_cmd.op == OP_CAPTURE) && out_valid && out_stall, "result overwritten while stalled")
	// A new result appears only through a capture.
	`NPR_ASSERT_IMPL(a_valid_from_capture, $rose(out_valid), $past(dp_cmd.op) == OP_CAPTURE, "result raised without capture")
	// While the input is open the datapath does nothing but a load.
	`NPR_ASSERT_IMPL(a_idle_quiet, !in_stall, (dp_cmd.op == OP_NONE) || (dp_cmd.op == OP_LOAD), "datapath busy while input open")

endmodule
